// ===== hdl/crac_pkg.sv =====
// Shared types and defaults for the coalescing range allocator.
// Used by the free-list cells and the allocator core; depends on nothing.
`timescale 1ns / 1ps

package crac_pkg;

    localparam int FREE_ENTRIES_DEF = 16;
    localparam int USED_ENTRIES_DEF = 64;
    localparam int ADDR_WIDTH_DEF   = 32;
    localparam int FIELD_W          = 32;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNKNOWN   = 3'd1,
        ST_USED_FULL = 3'd2,
        ST_FREE_FULL = 3'd3,
        ST_TOP_OVF   = 3'd4,
        ST_ZERO      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_USCAN,
        S_PASS1,
        S_PASS2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic fits;
        logic ends_at;
        logic starts_at;
    } cell_flags_t;

endpackage

// ===== hdl/crac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/crac_cell.sv =====
// One free-list cell: holds one free range and passes it on around the ring.
// Compares its range against the broadcast query; uses crac_pkg.
`timescale 1ns / 1ps

module crac_cell #(
    parameter int AW = 32,
    parameter int CW = 33
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 nxt_valid,
    input  logic [AW-1:0]        nxt_start,
    input  logic [AW-1:0]        nxt_len,
    input  logic [CW-1:0]        q_size,
    input  logic [CW-1:0]        q_start,
    input  logic [CW-1:0]        q_end,
    output logic                 ent_valid,
    output logic [AW-1:0]        ent_start,
    output logic [AW-1:0]        ent_len,
    output crac_pkg::cell_flags_t flags
);
    import crac_pkg::*;

    logic          valid_reg;
    logic [AW-1:0] start_reg;
    logic [AW-1:0] len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= nxt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            start_reg <= nxt_start;
            len_reg   <= nxt_len;
        end
    end

    always_comb
    begin
        flags.fits      = CW'(len_reg) >= q_size;
        flags.ends_at   = (CW'(start_reg) + CW'(len_reg)) == q_start;
        flags.starts_at = CW'(start_reg) == q_end;
    end

    assign ent_valid = valid_reg;
    assign ent_start = start_reg;
    assign ent_len   = len_reg;

endmodule

// ===== hdl/coalescing_range_allocator_core.sv =====
// Top level of the coalescing range allocator: request sequencer, free-list
// ring and used-range table. Depends on crac_pkg, crac_cell and crac_ram.
//
// One request is handled at a time. An allocate makes two rotations of the
// free-list ring when a free range fits and one rotation otherwise; zero size
// and full used table answer without a ring rotation. A free first scans the
// used table in RAM one entry a cycle (at most USED_ENTRIES entries, ending at
// the match; an unknown start answers right after the scan), then makes two
// rotations of the free-list ring (one rotation when no free slot is left). A
// finished result is held in an output register while the next request is
// taken.
`timescale 1ns / 1ps

module coalescing_range_allocator_core #(
    parameter int FREE_ENTRIES = crac_pkg::FREE_ENTRIES_DEF,
    parameter int USED_ENTRIES = crac_pkg::USED_ENTRIES_DEF,
    parameter int ADDR_WIDTH   = crac_pkg::ADDR_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [crac_pkg::FIELD_W-1:0]  request_size,
    input  logic [crac_pkg::FIELD_W-1:0]  release_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [crac_pkg::FIELD_W-1:0]  granted_start,
    output logic [2:0]                    status,
    output logic [crac_pkg::FIELD_W-1:0]  buffer_top
);
    import crac_pkg::*;

    localparam int AW  = ADDR_WIDTH;
    localparam int CW  = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
    localparam int FIW = $clog2(FREE_ENTRIES);
    localparam int UIW = $clog2(USED_ENTRIES);

    state_t               state_reg, state_next;
    logic                 act_reg, act_next;
    logic [CW-1:0]        size_reg, size_next;
    logic [CW-1:0]        rel_reg, rel_next;
    logic [UIW-1:0]       ucnt_reg, ucnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [UIW-1:0]       rd_tag_reg, rd_tag_next;
    logic [UIW-1:0]       uslot_reg, uslot_next;
    logic [UIW-1:0]       uidx_reg, uidx_next;
    logic [AW-1:0]        ulen_reg, ulen_next;
    logic [FIW-1:0]       fcnt_reg, fcnt_next;
    logic                 best_hit_reg, best_hit_next;
    logic [FIW-1:0]       best_reg, best_next;
    logic [AW-1:0]        best_start_reg, best_start_next;
    logic                 pred_hit_reg, pred_hit_next;
    logic [FIW-1:0]       pred_reg, pred_next;
    logic                 succ_hit_reg, succ_hit_next;
    logic [FIW-1:0]       succ_reg, succ_next;
    logic [AW-1:0]        succ_len_reg, succ_len_next;
    logic                 empty_hit_reg, empty_hit_next;
    logic [FIW-1:0]       empty_reg, empty_next;
    logic [USED_ENTRIES-1:0] used_valid_reg, used_valid_next;
    logic [AW-1:0]        top_reg, top_next;
    status_t              res_status_reg, res_status_next;
    logic [AW-1:0]        res_grant_reg, res_grant_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]   out_grant_reg, out_grant_next;
    status_t              out_status_reg, out_status_next;
    logic [FIELD_W-1:0]   out_top_reg, out_top_next;

    logic                 ring_shift;
    logic                 ent_valid [FREE_ENTRIES];
    logic [AW-1:0]        ent_start [FREE_ENTRIES];
    logic [AW-1:0]        ent_len   [FREE_ENTRIES];
    cell_flags_t          flags     [FREE_ENTRIES];
    logic                 h_valid;
    logic [AW-1:0]        h_start;
    logic [AW-1:0]        h_len;
    logic [CW-1:0]        q_end;
    logic                 fcnt_last;

    logic                 ram_we;
    logic [UIW-1:0]       ram_waddr;
    logic [2*AW-1:0]      ram_wdata;
    logic [2*AW-1:0]      ram_rdata;
    logic [UIW-1:0]       low_empty_used;

    assign q_end      = rel_reg + CW'(ulen_reg);
    assign ring_shift = (state_reg == S_PASS1) || (state_reg == S_PASS2);
    assign fcnt_last  = fcnt_reg == FIW'(FREE_ENTRIES - 1);

    genvar g;
    generate
        for (g = 0; g < FREE_ENTRIES; g++)
        begin : g_cell
            if (g == FREE_ENTRIES - 1)
            begin : g_tail
                crac_cell #(.AW(AW), .CW(CW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(ring_shift),
                    .nxt_valid(h_valid), .nxt_start(h_start), .nxt_len(h_len),
                    .q_size(size_reg), .q_start(rel_reg), .q_end(q_end),
                    .ent_valid(ent_valid[g]), .ent_start(ent_start[g]),
                    .ent_len(ent_len[g]), .flags(flags[g])
                );
            end
            else
            begin : g_body
                crac_cell #(.AW(AW), .CW(CW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(ring_shift),
                    .nxt_valid(ent_valid[g+1]), .nxt_start(ent_start[g+1]),
                    .nxt_len(ent_len[g+1]),
                    .q_size(size_reg), .q_start(rel_reg), .q_end(q_end),
                    .ent_valid(ent_valid[g]), .ent_start(ent_start[g]),
                    .ent_len(ent_len[g]), .flags(flags[g])
                );
            end
        end
    endgenerate

    crac_ram #(.WIDTH(2 * AW), .DEPTH(USED_ENTRIES)) u_used_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ucnt_reg), .rdata(ram_rdata)
    );

    always_comb
    begin
        low_empty_used = '0;
        for (int i = USED_ENTRIES - 1; i >= 0; i--)
        begin
            if (!used_valid_reg[i])
            begin
                low_empty_used = UIW'(i);
            end
        end
    end

    // Head of the ring: in the second pass, rewrite the chosen entry as it wraps to the tail.
    always_comb
    begin
        h_valid = ent_valid[0];
        h_start = ent_start[0];
        h_len   = ent_len[0];
        if (state_reg == S_PASS2)
        begin
            if (!act_reg)
            begin
                if (best_hit_reg && fcnt_reg == best_reg)
                begin
                    if (CW'(ent_len[0]) == size_reg)
                    begin
                        h_valid = 1'b0;
                    end
                    else
                    begin
                        h_start = ent_start[0] + AW'(size_reg);
                        h_len   = ent_len[0] - AW'(size_reg);
                    end
                end
            end
            else if (pred_hit_reg && fcnt_reg == pred_reg)
            begin
                h_len = ent_len[0] + ulen_reg + (succ_hit_reg ? succ_len_reg : '0);
            end
            else if (succ_hit_reg && fcnt_reg == succ_reg)
            begin
                if (pred_hit_reg)
                begin
                    h_valid = 1'b0;
                end
                else
                begin
                    h_start = AW'(rel_reg);
                    h_len   = ent_len[0] + ulen_reg;
                end
            end
            else if (!pred_hit_reg && !succ_hit_reg && fcnt_reg == empty_reg)
            begin
                h_valid = 1'b1;
                h_start = AW'(rel_reg);
                h_len   = ulen_reg;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        size_next       = size_reg;
        rel_next        = rel_reg;
        ucnt_next       = ucnt_reg;
        rd_pend_next    = 1'b0;
        rd_tag_next     = rd_tag_reg;
        uslot_next      = uslot_reg;
        uidx_next       = uidx_reg;
        ulen_next       = ulen_reg;
        fcnt_next       = fcnt_reg;
        best_hit_next   = best_hit_reg;
        best_next       = best_reg;
        best_start_next = best_start_reg;
        pred_hit_next   = pred_hit_reg;
        pred_next       = pred_reg;
        succ_hit_next   = succ_hit_reg;
        succ_next       = succ_reg;
        succ_len_next   = succ_len_reg;
        empty_hit_next  = empty_hit_reg;
        empty_next      = empty_reg;
        used_valid_next = used_valid_reg;
        top_next        = top_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        out_valid_next  = out_valid_reg;
        out_grant_next  = out_grant_reg;
        out_status_next = out_status_reg;
        out_top_next    = out_top_reg;
        ram_we          = 1'b0;
        ram_waddr       = uslot_reg;
        ram_wdata       = {AW'(size_reg), best_start_reg};
        in_ready        = state_reg == S_IDLE;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next        = action;
                    size_next       = CW'(request_size);
                    rel_next        = CW'(release_start);
                    ucnt_next       = '0;
                    fcnt_next       = '0;
                    best_hit_next   = 1'b0;
                    pred_hit_next   = 1'b0;
                    succ_hit_next   = 1'b0;
                    empty_hit_next  = 1'b0;
                    res_grant_next  = '0;
                    res_status_next = ST_OK;
                    uslot_next      = low_empty_used;
                    if (action)
                    begin
                        state_next = S_USCAN;
                    end
                    else if (request_size == '0)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else if (&used_valid_reg)
                    begin
                        res_status_next = ST_USED_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PASS1;
                    end
                end
            end

            S_USCAN:
            begin
                ucnt_next    = ucnt_reg + 1'b1;
                rd_pend_next = 1'b1;
                rd_tag_next  = ucnt_reg;
                if (rd_pend_reg)
                begin
                    if (used_valid_reg[rd_tag_reg] && CW'(ram_rdata[AW-1:0]) == rel_reg)
                    begin
                        uidx_next    = rd_tag_reg;
                        ulen_next    = ram_rdata[2*AW-1:AW];
                        rd_pend_next = 1'b0;
                        state_next   = S_PASS1;
                    end
                    else if (rd_tag_reg == UIW'(USED_ENTRIES - 1))
                    begin
                        rd_pend_next    = 1'b0;
                        res_status_next = ST_UNKNOWN;
                        state_next      = S_DONE;
                    end
                end
            end

            S_PASS1:
            begin
                fcnt_next = fcnt_last ? '0 : fcnt_reg + 1'b1;
                if (!act_reg)
                begin
                    if (ent_valid[0] && flags[0].fits &&
                        (!best_hit_reg || ent_start[0] > best_start_reg))
                    begin
                        best_hit_next   = 1'b1;
                        best_next       = fcnt_reg;
                        best_start_next = ent_start[0];
                    end
                end
                else if (ent_valid[0])
                begin
                    if (!pred_hit_reg && flags[0].ends_at)
                    begin
                        pred_hit_next = 1'b1;
                        pred_next     = fcnt_reg;
                    end
                    else if (!succ_hit_reg && flags[0].starts_at)
                    begin
                        succ_hit_next = 1'b1;
                        succ_next     = fcnt_reg;
                        succ_len_next = ent_len[0];
                    end
                end
                else if (!empty_hit_reg)
                begin
                    empty_hit_next = 1'b1;
                    empty_next     = fcnt_reg;
                end

                if (fcnt_last)
                begin
                    if (!act_reg)
                    begin
                        if (best_hit_next)
                        begin
                            ram_we                     = 1'b1;
                            ram_wdata                  = {AW'(size_reg), best_start_next};
                            used_valid_next[uslot_reg] = 1'b1;
                            res_grant_next             = best_start_next;
                            state_next                 = S_PASS2;
                        end
                        else if (size_reg > (CW'({AW{1'b1}}) - CW'(top_reg)))
                        begin
                            res_status_next = ST_TOP_OVF;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_we                     = 1'b1;
                            ram_wdata                  = {AW'(size_reg), top_reg};
                            used_valid_next[uslot_reg] = 1'b1;
                            res_grant_next             = top_reg;
                            top_next                   = top_reg + AW'(size_reg);
                            state_next                 = S_DONE;
                        end
                    end
                    else if (!pred_hit_next && !succ_hit_next && !empty_hit_next)
                    begin
                        res_status_next = ST_FREE_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        used_valid_next[uidx_reg] = 1'b0;
                        state_next                = S_PASS2;
                    end
                end
            end

            S_PASS2:
            begin
                fcnt_next = fcnt_last ? '0 : fcnt_reg + 1'b1;
                if (fcnt_last)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_grant_next  = (res_status_reg == ST_OK) ? FIELD_W'(res_grant_reg) : '0;
                    out_top_next    = FIELD_W'(top_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_pend_reg    <= 1'b0;
            fcnt_reg       <= '0;
            used_valid_reg <= '0;
            top_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pend_reg    <= rd_pend_next;
            fcnt_reg       <= fcnt_next;
            used_valid_reg <= used_valid_next;
            top_reg        <= top_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        size_reg       <= size_next;
        rel_reg        <= rel_next;
        ucnt_reg       <= ucnt_next;
        rd_tag_reg     <= rd_tag_next;
        uslot_reg      <= uslot_next;
        uidx_reg       <= uidx_next;
        ulen_reg       <= ulen_next;
        best_hit_reg   <= best_hit_next;
        best_reg       <= best_next;
        best_start_reg <= best_start_next;
        pred_hit_reg   <= pred_hit_next;
        pred_reg       <= pred_next;
        succ_hit_reg   <= succ_hit_next;
        succ_reg       <= succ_next;
        succ_len_reg   <= succ_len_next;
        empty_hit_reg  <= empty_hit_next;
        empty_reg      <= empty_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        out_grant_reg  <= out_grant_next;
        out_status_reg <= out_status_next;
        out_top_reg    <= out_top_next;
    end

    assign out_valid     = out_valid_reg;
    assign granted_start = out_grant_reg;
    assign status        = out_status_reg;
    assign buffer_top    = out_top_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("transfer accepted but sequencer stayed idle");

    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (fcnt_reg == '0))
        else $error("free ring not back in home position");

    a_alloc_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !act_reg && res_status_reg == ST_OK)
        |-> used_valid_reg[uslot_reg])
        else $error("granted range missing from used table");

    a_scan_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rd_pend_reg)
        else $error("used table read pending while idle");
`endif

endmodule
